// ===== hw/rtl/bqc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the biquad cascade unit.
package bqc_pkg;

    localparam int DEF_MAX_STAGES = 8;
    localparam int STAGE_IDX_W    = 5;
    localparam int SAMPLE_W       = 16;
    localparam int PROD_W         = 32;
    localparam int ACC_W          = 35;
    localparam int CFG_IDX_W      = 1;
    localparam int CFG_DATA_W     = 4;

    localparam logic FUNC_FILTER = 1'b0;
    localparam logic FUNC_COEF   = 1'b1;

    localparam logic [2:0] SLOT_B0 = 3'd0;
    localparam logic [2:0] SLOT_B1 = 3'd1;
    localparam logic [2:0] SLOT_B2 = 3'd2;
    localparam logic [2:0] SLOT_A1 = 3'd3;
    localparam logic [2:0] SLOT_A2 = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_STAGES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_POST_SHIFT    = 1'b1;

    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 16'sh8000;

    typedef struct packed {
        logic                   load_x;
        logic                   coef_wr;
        logic                   mul;
        logic                   first;
        logic                   fin;
        logic                   out_load;
        logic [2:0]             slot;
        logic [STAGE_IDX_W-1:0] stage;
    } bqc_cmd_t;

    typedef struct packed {
        logic [STAGE_IDX_W-1:0] last_stage;
    } bqc_status_t;

endpackage

// ===== hw/rtl/biquad_cascade_df1_q15_unit.sv =====
`timescale 1ns / 1ps
// Top level of the Q15 direct form I biquad cascade.
//
//  channel  | signals                                          | direction
//  ---------+--------------------------------------------------+----------
//  input    | in_valid/in_ready, func, sample_in, block_end,   | in
//           | coef_stage, coef_slot, coef_value                |
//  output   | out_valid/out_ready, sample_out, block_last      | out
//  config   | cfg_we, cfg_index, cfg_data                      | in
//
// A filter transaction raises out_valid once all N active sections have run (each section:
// multiply steps for B0, B1, B2, A1 and A2, then a shift/saturate/history step); in_ready returns
// with out_valid, so the unit takes no new transaction while a filter transaction is in progress.
// A coefficient write gives no result.
// Reset clears all coefficients and history; active_stages is 1, post_shift 0.
// A held output only stalls the finish cycle of the last section.
module biquad_cascade_df1_q15_unit
    import bqc_pkg::*;
#(
    parameter int MAX_STAGES = DEF_MAX_STAGES
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        func,
    input  logic signed [SAMPLE_W-1:0]  sample_in,
    input  logic                        block_end,
    input  logic [2:0]                  coef_stage,
    input  logic [2:0]                  coef_slot,
    input  logic signed [SAMPLE_W-1:0]  coef_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic signed [SAMPLE_W-1:0]  sample_out,
    output logic                        block_last,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data
);

    bqc_cmd_t    cmd;
    bqc_status_t status;

    bqc_ctrl #(
        .MAX_STAGES (MAX_STAGES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    bqc_dp #(
        .MAX_STAGES (MAX_STAGES)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .sample_in  (sample_in),
        .block_end  (block_end),
        .coef_stage (coef_stage),
        .coef_slot  (coef_slot),
        .coef_value (coef_value),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .sample_out (sample_out),
        .block_last (block_last)
    );

endmodule

// ===== hw/rtl/bqc_dp.sv =====
`timescale 1ns / 1ps
// Datapath: coefficient and history storage, shared MAC, shift and saturation.
module bqc_dp
    import bqc_pkg::*;
#(
    parameter int MAX_STAGES = DEF_MAX_STAGES
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  bqc_cmd_t                    cmd,
    output bqc_status_t                 status,
    input  logic signed [SAMPLE_W-1:0]  sample_in,
    input  logic                        block_end,
    input  logic [2:0]                  coef_stage,
    input  logic [2:0]                  coef_slot,
    input  logic signed [SAMPLE_W-1:0]  coef_value,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]       cfg_data,
    output logic signed [SAMPLE_W-1:0]  sample_out,
    output logic                        block_last
);

    localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

    logic signed [SAMPLE_W-1:0] b0_reg [MAX_STAGES];
    logic signed [SAMPLE_W-1:0] b1_reg [MAX_STAGES];
    logic signed [SAMPLE_W-1:0] b2_reg [MAX_STAGES];
    logic signed [SAMPLE_W-1:0] a1_reg [MAX_STAGES];
    logic signed [SAMPLE_W-1:0] a2_reg [MAX_STAGES];
    logic signed [SAMPLE_W-1:0] x1_reg [MAX_STAGES];
    logic signed [SAMPLE_W-1:0] x2_reg [MAX_STAGES];
    logic signed [SAMPLE_W-1:0] y1_reg [MAX_STAGES];
    logic signed [SAMPLE_W-1:0] y2_reg [MAX_STAGES];

    logic [3:0]                 active_stages_reg;
    logic [3:0]                 post_shift_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic                       blk_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] out_data_reg;
    logic                       out_last_reg;

    logic [SW-1:0]              st;
    logic [SW-1:0]              wst;
    logic                       wr_ok;
    logic signed [SAMPLE_W-1:0] cf_sel;
    logic signed [SAMPLE_W-1:0] op_sel;
    logic signed [PROD_W-1:0]   prod;
    logic signed [ACC_W-1:0]    sum;
    logic signed [ACC_W-1:0]    shifted;
    logic [3:0]                 shamt;
    logic signed [SAMPLE_W-1:0] y;
    int                         n_stages;

    assign st    = cmd.stage[SW-1:0];
    assign wst   = SW'(coef_stage);
    assign wr_ok = cmd.coef_wr && (32'(coef_stage) < 32'(MAX_STAGES));

    always_comb
    begin
        n_stages = int'(active_stages_reg);
        if (n_stages < 1)
        begin
            n_stages = 1;
        end
        if (n_stages > MAX_STAGES)
        begin
            n_stages = MAX_STAGES;
        end
        status.last_stage = STAGE_IDX_W'(n_stages - 1);
    end

    always_comb
    begin
        case (cmd.slot)
            SLOT_B0:
            begin
                cf_sel = b0_reg[st];
                op_sel = x_reg;
            end
            SLOT_B1:
            begin
                cf_sel = b1_reg[st];
                op_sel = x1_reg[st];
            end
            SLOT_B2:
            begin
                cf_sel = b2_reg[st];
                op_sel = x2_reg[st];
            end
            SLOT_A1:
            begin
                cf_sel = a1_reg[st];
                op_sel = y1_reg[st];
            end
            SLOT_A2:
            begin
                cf_sel = a2_reg[st];
                op_sel = y2_reg[st];
            end
            default:
            begin
                cf_sel = '0;
                op_sel = '0;
            end
        endcase
    end

    assign prod    = cf_sel * op_sel;
    assign sum     = acc_reg + ACC_W'(prod_reg);
    assign shamt   = ~post_shift_reg;
    assign shifted = sum >>> shamt;

    always_comb
    begin
        if (shifted > ACC_W'(SAT_MAX))
        begin
            y = SAT_MAX;
        end
        else if (shifted < ACC_W'(SAT_MIN))
        begin
            y = SAT_MIN;
        end
        else
        begin
            y = shifted[SAMPLE_W-1:0];
        end
    end

    // Coefficients and history: cleared by reset; active_stages resets to 1, post_shift to 0.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_STAGES; i++)
            begin
                b0_reg[i] <= '0;
                b1_reg[i] <= '0;
                b2_reg[i] <= '0;
                a1_reg[i] <= '0;
                a2_reg[i] <= '0;
                x1_reg[i] <= '0;
                x2_reg[i] <= '0;
                y1_reg[i] <= '0;
                y2_reg[i] <= '0;
            end
            active_stages_reg <= 4'd1;
            post_shift_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ACTIVE_STAGES: active_stages_reg <= cfg_data;
                    CFG_POST_SHIFT:    post_shift_reg    <= cfg_data;
                    default:           ;
                endcase
            end
            if (wr_ok)
            begin
                case (coef_slot)
                    SLOT_B0: b0_reg[wst] <= coef_value;
                    SLOT_B1: b1_reg[wst] <= coef_value;
                    SLOT_B2: b2_reg[wst] <= coef_value;
                    SLOT_A1: a1_reg[wst] <= coef_value;
                    SLOT_A2: a2_reg[wst] <= coef_value;
                    default: ;
                endcase
            end
            if (cmd.fin)
            begin
                x1_reg[st] <= x_reg;
                x2_reg[st] <= x1_reg[st];
                y1_reg[st] <= y;
                y2_reg[st] <= y1_reg[st];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_x)
        begin
            x_reg   <= sample_in;
            blk_reg <= block_end;
        end
        else if (cmd.fin)
        begin
            x_reg <= y;
        end
        if (cmd.mul)
        begin
            prod_reg <= prod;
            acc_reg  <= cmd.first ? '0 : sum;
        end
        if (cmd.out_load)
        begin
            out_data_reg <= y;
            out_last_reg <= blk_reg;
        end
    end

    assign sample_out = out_data_reg;
    assign block_last = out_last_reg;

endmodule

// ===== hw/rtl/bqc_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences sections and MAC slots, owns the output handshake.
module bqc_ctrl
    import bqc_pkg::*;
#(
    parameter int MAX_STAGES = DEF_MAX_STAGES
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        func,
    output logic        out_valid,
    input  logic        out_ready,
    input  bqc_status_t status,
    output bqc_cmd_t    cmd
);

    localparam int SW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t        state_reg, state_next;
    logic [SW-1:0] stage_reg, stage_next;
    logic [2:0]    slot_reg, slot_next;
    logic          out_valid_reg, out_valid_next;

    logic          accept;
    logic          is_last;
    logic          fin_go;

    assign accept  = in_valid && in_ready;
    assign is_last = (stage_reg == status.last_stage[SW-1:0]);
    assign fin_go  = (state_reg == ST_FIN) && !(is_last && out_valid_reg && !out_ready);

    always_comb
    begin
        state_next = state_reg;
        stage_next = stage_reg;
        slot_next  = slot_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && func == FUNC_FILTER)
                begin
                    state_next = ST_MUL;
                    stage_next = '0;
                    slot_next  = SLOT_B0;
                end
            end
            ST_MUL:
            begin
                if (slot_reg == SLOT_A2)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    slot_next = slot_reg + 3'd1;
                end
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    slot_next = SLOT_B0;
                    if (is_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_MUL;
                        stage_next = stage_reg + SW'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_go && is_last)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stage_reg     <= '0;
            slot_reg      <= SLOT_B0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stage_reg     <= stage_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.load_x   = accept && func == FUNC_FILTER;
        cmd.coef_wr  = accept && func == FUNC_COEF;
        cmd.mul      = (state_reg == ST_MUL);
        cmd.first    = (slot_reg == SLOT_B0);
        cmd.fin      = fin_go;
        cmd.out_load = fin_go && is_last;
        cmd.slot     = slot_reg;
        cmd.stage    = STAGE_IDX_W'(stage_reg);
    end

endmodule

// ===== test/tb_biquad_cascade_df1_q15_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Q15 biquad cascade unit.
module tb_biquad_cascade_df1_q15_unit;
    import bqc_pkg::*;

    localparam int MAX_ST    = DEF_MAX_STAGES;
    localparam int DRAIN_CYC = 6 * MAX_ST + 1 + 12;
    localparam int LIMIT_CYC = 1000000;
    localparam int PHASE_LEN = 80;

    localparam logic [2:0] SLOT_UNUSED_5 = 3'd5;
    localparam logic [2:0] SLOT_UNUSED_7 = 3'd7;

    localparam int H_X1 = 0;
    localparam int H_X2 = 1;
    localparam int H_Y1 = 2;
    localparam int H_Y2 = 3;

    typedef struct packed {
        logic               func;
        logic signed [15:0] sample;
        logic               blk;
        logic [2:0]         stage;
        logic [2:0]         slot;
        logic signed [15:0] value;
        logic               fixed;
        logic signed [15:0] want;
    } stim_t;

    typedef struct packed {
        logic signed [15:0] smp;
        logic               last;
    } filt_out_t;

    logic                        clk;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic                        in_ready;
    logic                        func       = FUNC_FILTER;
    logic signed [SAMPLE_W-1:0]  sample_in  = '0;
    logic                        block_end  = 1'b0;
    logic [2:0]                  coef_stage = '0;
    logic [2:0]                  coef_slot  = '0;
    logic signed [SAMPLE_W-1:0]  coef_value = '0;
    logic                        out_valid;
    logic                        out_ready  = 1'b0;
    logic signed [SAMPLE_W-1:0]  sample_out;
    logic                        block_last;
    logic                        cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_index  = '0;
    logic [CFG_DATA_W-1:0]       cfg_data   = '0;

    logic signed [15:0] coef_mem [MAX_ST][5];
    logic signed [15:0] hist_mem [MAX_ST][4];
    logic [3:0]         stages_cfg;
    logic [3:0]         shift_cfg;

    filt_out_t pending_out[$];
    stim_t     dir_rows[$];
    int        mismatch_cnt = 0;
    int        cyc_cnt = 0;
    int        rdy_hold = 0;
    logic      calm = 1'b0;
    filt_out_t got_out;
    filt_out_t want_out;

    biquad_cascade_df1_q15_unit #(
        .MAX_STAGES(MAX_ST)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .sample_in  (sample_in),
        .block_end  (block_end),
        .coef_stage (coef_stage),
        .coef_slot  (coef_slot),
        .coef_value (coef_value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .block_last (block_last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic stim_t filt(input int s, input logic be, input logic fx, input int w);
        stim_t it;
        it = '0;
        it.func   = FUNC_FILTER;
        it.sample = 16'(s);
        it.blk    = be;
        it.fixed  = fx;
        it.want   = 16'(w);
        return it;
    endfunction

    function automatic stim_t coef_wr(input logic [2:0] st, input logic [2:0] sl, input int v);
        stim_t it;
        it = '0;
        it.func  = FUNC_COEF;
        it.stage = st;
        it.slot  = sl;
        it.value = 16'(v);
        return it;
    endfunction

    // Cascade predictor: updates coefficient/history state, queues the expected result.
    function automatic void run_cascade(input stim_t it);
        logic signed [39:0] acc;
        logic signed [15:0] x;
        logic signed [15:0] y;
        int                 n;
        int                 sh;
        filt_out_t          r;
        if (it.func == FUNC_COEF)
        begin
            if (it.stage < MAX_ST && it.slot <= SLOT_A2)
                coef_mem[it.stage][it.slot] = it.value;
            return;
        end
        n = int'(stages_cfg);
        if (n < 1)
            n = 1;
        if (n > MAX_ST)
            n = MAX_ST;
        sh = 15 - int'(shift_cfg);
        x = it.sample;
        for (int s = 0; s < n; s++)
        begin
            acc = 40'sd0;
            acc = acc + coef_mem[s][SLOT_B0] * x;
            acc = acc + coef_mem[s][SLOT_B1] * hist_mem[s][H_X1];
            acc = acc + coef_mem[s][SLOT_B2] * hist_mem[s][H_X2];
            acc = acc + coef_mem[s][SLOT_A1] * hist_mem[s][H_Y1];
            acc = acc + coef_mem[s][SLOT_A2] * hist_mem[s][H_Y2];
            acc = acc >>> sh;
            if (acc > 40'sd32767)
                y = SAT_MAX;
            else if (acc < -40'sd32768)
                y = SAT_MIN;
            else
                y = acc[15:0];
            hist_mem[s][H_X2] = hist_mem[s][H_X1];
            hist_mem[s][H_X1] = x;
            hist_mem[s][H_Y2] = hist_mem[s][H_Y1];
            hist_mem[s][H_Y1] = y;
            x = y;
        end
        r.smp  = it.fixed ? it.want : x;
        r.last = it.blk;
        pending_out.push_back(r);
    endfunction

    function automatic logic signed [15:0] rand_coef();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return 16'($urandom());
        if (r < 9)
            return 16'($urandom_range(0, 16383) - 8192);
        return ($urandom_range(0, 1) != 0) ? SAT_MAX : SAT_MIN;
    endfunction

    function automatic stim_t rand_item();
        stim_t it;
        int    r;
        it = '0;
        it.value = rand_coef();
        it.stage = 3'($urandom_range(0, MAX_ST - 1));
        it.blk   = ($urandom_range(0, 7) == 0);
        r = $urandom_range(0, 99);
        if (r < 12)
        begin
            it.func = FUNC_COEF;
            it.slot = 3'($urandom_range(SLOT_B0, SLOT_A2));
        end
        else if (r < 15)
        begin
            it.func = FUNC_COEF;
            it.slot = 3'($urandom_range(SLOT_UNUSED_5, SLOT_UNUSED_7));
        end
        else
        begin
            it.func = FUNC_FILTER;
            it.slot = 3'($urandom());
            r = $urandom_range(0, 19);
            if (r == 0)
                it.sample = SAT_MAX;
            else if (r == 1)
                it.sample = SAT_MIN;
            else
                it.sample = 16'($urandom());
        end
        return it;
    endfunction

    task automatic send_item(input stim_t it);
        int gap;
        gap = calm ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= it.func;
        sample_in  <= it.sample;
        block_end  <= it.blk;
        coef_stage <= it.stage;
        coef_slot  <= it.slot;
        coef_value <= it.value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        run_cascade(it);
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (pending_out.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYC) @(posedge clk);
    endtask

    task automatic set_config(input logic [3:0] st, input logic [3:0] ps);
        drain_outputs();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ACTIVE_STAGES;
        cfg_data  <= st;
        @(posedge clk);
        cfg_index <= CFG_POST_SHIFT;
        cfg_data  <= ps;
        @(posedge clk);
        cfg_we     <= 1'b0;
        stages_cfg = st;
        shift_cfg  = ps;
    endtask

    // Load a set of moderate coefficients into every section in use.
    task automatic load_sections();
        int n;
        n = (stages_cfg < 1) ? 1 : (stages_cfg > MAX_ST) ? MAX_ST : int'(stages_cfg);
        for (int s = 0; s < n; s++)
        begin
            send_item(coef_wr(3'(s), SLOT_B0, $urandom_range(0, 8191) - 4096));
            send_item(coef_wr(3'(s), SLOT_B1, $urandom_range(0, 8191) - 4096));
            send_item(coef_wr(3'(s), SLOT_B2, $urandom_range(0, 8191) - 4096));
            send_item(coef_wr(3'(s), SLOT_A1, $urandom_range(0, 24575) - 12288));
            send_item(coef_wr(3'(s), SLOT_A2, $urandom_range(0, 12287) - 8192));
        end
    endtask

    always @(posedge clk)
    begin
        if (calm)
        begin
            out_ready <= 1'b1;
            rdy_hold  <= 0;
        end
        else if (rdy_hold > 0)
            rdy_hold <= rdy_hold - 1;
        else if (out_ready)
        begin
            out_ready <= 1'b0;
            rdy_hold  <= pick_gap();
        end
        else
        begin
            out_ready <= 1'b1;
            rdy_hold  <= $urandom_range(0, 8);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_out.smp  = sample_out;
            got_out.last = block_last;
            if (pending_out.size() == 0)
            begin
                $display("%0t: unexpected transaction: got sample_out %0d block_last %0b",
                         $time, got_out.smp, got_out.last);
                mismatch_cnt++;
            end
            else
            begin
                want_out = pending_out.pop_front();
                if (got_out.smp !== want_out.smp)
                begin
                    $display("%0t: sample_out mismatch: expected %0d, got %0d",
                             $time, want_out.smp, got_out.smp);
                    mismatch_cnt++;
                end
                if (got_out.last !== want_out.last)
                begin
                    $display("%0t: block_last mismatch: expected %0b, got %0b",
                             $time, want_out.last, got_out.last);
                    mismatch_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cyc_cnt++;
        if (cyc_cnt > LIMIT_CYC)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_out.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        logic [3:0] st_list [12];
        logic [3:0] ps_list [12];
        st_list = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd9, 4'd3, 4'd8, 4'd5, 4'd2, 4'd8, 4'd4, 4'd6};
        ps_list = '{4'd0, 4'd15, 4'd7, 4'd3, 4'd0, 4'd14, 4'd15, 4'd1, 4'd8, 4'd0, 4'd12, 4'd10};
        for (int s = 0; s < MAX_ST; s++)
        begin
            for (int k = 0; k < 5; k++)
                coef_mem[s][k] = '0;
            for (int k = 0; k < 4; k++)
                hist_mem[s][k] = '0;
        end
        stages_cfg = 4'd1;
        shift_cfg  = 4'd0;

        // zero coefficients after reset
        dir_rows.push_back(filt(32767, 1'b1, 1'b1, 0));
        dir_rows.push_back(filt(-32768, 1'b0, 1'b1, 0));
        dir_rows.push_back(coef_wr(3'd0, SLOT_B0, 32767));
        dir_rows.push_back(filt(16384, 1'b0, 1'b1, 16383));
        // writes to unused slots are dropped
        dir_rows.push_back(coef_wr(3'd0, SLOT_UNUSED_5, 16'sh1234));
        dir_rows.push_back(coef_wr(3'd0, SLOT_UNUSED_7, -1));
        dir_rows.push_back(filt(16384, 1'b1, 1'b1, 16383));
        dir_rows.push_back(coef_wr(3'd0, SLOT_B0, -32768));
        dir_rows.push_back(filt(-32768, 1'b0, 1'b1, 32767));
        dir_rows.push_back(filt(32767, 1'b0, 1'b1, -32767));
        // three full-scale products overflow 32 bits
        dir_rows.push_back(coef_wr(3'd0, SLOT_B1, -32768));
        dir_rows.push_back(coef_wr(3'd0, SLOT_B2, -32768));
        dir_rows.push_back(filt(-32768, 1'b0, 1'b0, 0));
        dir_rows.push_back(filt(-32768, 1'b0, 1'b0, 0));
        dir_rows.push_back(filt(-32768, 1'b1, 1'b1, 32767));
        dir_rows.push_back(coef_wr(3'd0, SLOT_A1, 16384));
        dir_rows.push_back(coef_wr(3'd0, SLOT_A2, -8192));
        dir_rows.push_back(coef_wr(3'd0, SLOT_B0, 8192));
        dir_rows.push_back(coef_wr(3'd0, SLOT_B1, 16384));
        dir_rows.push_back(coef_wr(3'd0, SLOT_B2, 8192));
        dir_rows.push_back(filt(12000, 1'b0, 1'b0, 0));
        dir_rows.push_back(filt(-20000, 1'b0, 1'b0, 0));
        dir_rows.push_back(filt(0, 1'b1, 1'b0, 0));
        dir_rows.push_back(coef_wr(3'd7, SLOT_A2, 32767));
        dir_rows.push_back(coef_wr(3'd1, SLOT_B0, 32767));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i]);

        for (int p = 0; p < 12; p++)
        begin
            set_config(st_list[p], ps_list[p]);
            calm <= (p % 4 == 3);
            if ($urandom_range(0, 2) != 0)
                load_sections();
            for (int k = 0; k < PHASE_LEN; k++)
                send_item(rand_item());
        end

        drain_outputs();
        if (mismatch_cnt == 0 && pending_out.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== biquad_cascade_df1_q15_unit.f =====
hw/rtl/bqc_pkg.sv
hw/rtl/bqc_dp.sv
hw/rtl/bqc_ctrl.sv
hw/rtl/biquad_cascade_df1_q15_unit.sv
test/tb_biquad_cascade_df1_q15_unit.sv
